// ===== rtl/mlfq_pkg.sv =====
`timescale 1ns / 1ps
package mlfq_pkg;

  typedef enum logic [3:0] {
    OP_CREATE  = 4'd0,
    OP_YIELD   = 4'd1,
    OP_SCHED   = 4'd2,
    OP_EXIT    = 4'd3,
    OP_QUERY   = 4'd4,
    OP_RELEASE = 4'd5,
    OP_MINIT   = 4'd6,
    OP_LOCK    = 4'd7,
    OP_UNLOCK  = 4'd8,
    OP_DESTROY = 4'd9
  } op_e;

  typedef enum logic [2:0] {
    RC_OK       = 3'd0,
    RC_FULL     = 3'd1,
    RC_NOTFOUND = 3'd2,
    RC_NONE     = 3'd3,
    RC_BLOCKED  = 3'd4
  } code_e;

  typedef enum logic [1:0] {
    TS_READY   = 2'd0,
    TS_SCHED   = 2'd1,
    TS_BLOCKED = 2'd2,
    TS_TERM    = 2'd3
  } tstat_e;

endpackage

// ===== rtl/mlfq_link_ram.sv =====
`timescale 1ns / 1ps
module mlfq_link_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 5,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mlfq_thread_scheduler.sv =====
`timescale 1ns / 1ps
// query, create, lock, unlock and mutex init reach the result word without a walk, but for the cases below
// yield, blocking lock and release walk one queue link a cycle
// schedule walks levels and links one a cycle
// exit scans all mutexes
// destroy and init of a used mutex walk waiters
// one word in flight at a time; the next is taken once the result is in the output register
// asynchronous active-low reset clears all control state at once, no clearing pass
module mlfq_thread_scheduler #(
  parameter int LEVELS      = 4,
  parameter int MAX_THREADS = 16,
  parameter int MAX_MUTEXES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_sched_mode_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [3:0] op_i,
  input  logic [3:0] thread_slot_i,
  input  logic [2:0] mutex_slot_i,
  input  logic       full_slice_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] result_thread_o,
  output logic [2:0] result_code_o,
  output logic       finished_o
);
  import mlfq_pkg::*;

  localparam int TW  = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int MW  = (MAX_MUTEXES > 1) ? $clog2(MAX_MUTEXES) : 1;
  localparam int LCW = $clog2(LEVELS + 1);
  localparam int MCW = $clog2(MAX_MUTEXES + 1);

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_DISP    = 14'b00000000000010,
    S_RM_CHK  = 14'b00000000000100,
    S_AP1     = 14'b00000000001000,
    S_AP2     = 14'b00000000010000,
    S_PK_LVL  = 14'b00000000100000,
    S_PK_CHK  = 14'b00000001000000,
    S_ROT1    = 14'b00000010000000,
    S_ROT2    = 14'b00000100000000,
    S_EX_SCAN = 14'b00001000000000,
    S_EX_HO   = 14'b00010000000000,
    S_UL_HO   = 14'b00100000000000,
    S_DR_STEP = 14'b01000000000000,
    S_RESP    = 14'b10000000000000
  } state_e;

  localparam logic [TW:0] LINK_NIL = {1'b1, {TW{1'b0}}};

  state_e       state_q;
  logic [3:0]   op_q, ts_q;
  logic [2:0]   ms_q;
  logic         full_q, mode_q;

  logic         used_q   [MAX_THREADS];
  tstat_e       stat_q   [MAX_THREADS];
  logic [LW-1:0] level_q [MAX_THREADS];
  logic [TW-1:0] head_q  [LEVELS];
  logic [TW-1:0] tail_q  [LEVELS];
  logic         filled_q [LEVELS];
  logic [TW-1:0] run_q;
  logic         run_valid_q;
  logic         mu_used_q   [MAX_MUTEXES];
  logic         mu_locked_q [MAX_MUTEXES];
  logic [TW-1:0] owner_q    [MAX_MUTEXES];
  logic [TW:0]  top_q       [MAX_MUTEXES];

  logic [TW-1:0] wt_q, cur_q, prev_q;
  logic [LW-1:0] wl_q, ap_q;
  logic         prev_nil_q, rm_then_ap_q;
  logic [LCW-1:0] sl_q;
  logic [MCW-1:0] mi_q;
  logic [3:0]   res_thread_q;
  code_e        res_code_q;
  logic         res_fin_q;
  logic         out_valid_q;
  logic [3:0]   out_thread_q;
  code_e        out_code_q;
  logic         out_fin_q;

  logic         q_we, q_re, w_we, w_re;
  logic [TW-1:0] q_waddr, q_raddr, w_waddr, w_raddr;
  logic [TW:0]  q_wdata, q_rdata, w_wdata, w_rdata;

  logic [TW-1:0] ts_idx, free_idx, rm_tgt;
  logic [MW-1:0] ms_idx, mi_idx;
  logic [LW-1:0] sl_idx, rm_lvl, yield_lvl;
  logic         have_run, t_ok, m_ok, free_found, need_rm;
  logic         scan_end, ex_end, ex_hit, runnable_cur, rm_hit, rm_tail, pk_tail, drop_go;

  assign ts_idx = TW'(ts_q);
  assign ms_idx = MW'(ms_q);
  assign mi_idx = MW'(mi_q);
  assign sl_idx = LW'(sl_q);
  assign have_run = run_valid_q && used_q[run_q];
  assign t_ok = (32'(ts_q) < MAX_THREADS) && used_q[ts_idx];
  assign m_ok = (32'(ms_q) < MAX_MUTEXES) && mu_used_q[ms_idx];
  assign scan_end = (sl_q == LCW'(LEVELS));
  assign ex_end = (mi_q == MCW'(MAX_MUTEXES));
  assign ex_hit = mu_used_q[mi_idx] && mu_locked_q[mi_idx] && (owner_q[mi_idx] == run_q);
  assign runnable_cur = (stat_q[cur_q] != TS_BLOCKED) && (stat_q[cur_q] != TS_TERM);
  assign rm_hit = (cur_q == wt_q);
  assign rm_tail = (cur_q == tail_q[wl_q]);
  assign pk_tail = (cur_q == tail_q[sl_idx]);
  assign rm_tgt = (op_q == OP_RELEASE) ? ts_idx : run_q;
  assign rm_lvl = level_q[rm_tgt];
  assign yield_lvl = (mode_q && full_q && (32'(level_q[run_q]) + 1 < LEVELS))
                     ? LW'(level_q[run_q] + 1'b1) : level_q[run_q];
  assign drop_go = ((op_q == OP_DESTROY) && m_ok) ||
                   ((op_q == OP_MINIT) && (32'(ms_q) < MAX_MUTEXES) && mu_used_q[ms_idx]);

  always_comb begin
    need_rm = 1'b0;
    case (op_q)
      OP_YIELD:   need_rm = have_run;
      OP_LOCK:    need_rm = m_ok && have_run && mu_locked_q[ms_idx];
      OP_RELEASE: need_rm = t_ok && (stat_q[ts_idx] == TS_TERM);
      default:    need_rm = 1'b0;
    endcase
  end

  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = MAX_THREADS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_idx = TW'(i);
      end
    end
  end

  // link memory port control
  always_comb begin
    q_we = 1'b0; q_waddr = '0; q_wdata = LINK_NIL;
    q_re = 1'b0; q_raddr = '0;
    w_we = 1'b0; w_waddr = '0; w_wdata = LINK_NIL;
    w_re = 1'b0; w_raddr = '0;
    case (state_q)
      S_DISP: begin
        if (need_rm && filled_q[rm_lvl]) begin
          q_re = 1'b1; q_raddr = head_q[rm_lvl];
        end
        if (op_q == OP_LOCK && need_rm) begin
          w_we = 1'b1; w_waddr = run_q; w_wdata = top_q[ms_idx];
        end
        if (((op_q == OP_UNLOCK && m_ok) || drop_go) && !top_q[ms_idx][TW]) begin
          w_re = 1'b1; w_raddr = top_q[ms_idx][TW-1:0];
        end
      end
      S_RM_CHK: begin
        if (!rm_hit && !rm_tail) begin
          q_re = 1'b1; q_raddr = q_rdata[TW-1:0];
        end
        if (rm_hit && !prev_nil_q) begin
          q_we = 1'b1; q_waddr = prev_q; q_wdata = q_rdata;
        end
      end
      S_AP1: begin
        if (filled_q[ap_q]) begin
          q_we = 1'b1; q_waddr = tail_q[ap_q]; q_wdata = {1'b0, wt_q};
        end
      end
      S_AP2: begin
        q_we = 1'b1; q_waddr = wt_q; q_wdata = LINK_NIL;
      end
      S_PK_LVL: begin
        if (!scan_end && filled_q[sl_idx]) begin
          q_re = 1'b1; q_raddr = head_q[sl_idx];
        end
      end
      S_PK_CHK: begin
        if (!runnable_cur && !pk_tail) begin
          q_re = 1'b1; q_raddr = q_rdata[TW-1:0];
        end
      end
      S_ROT1: begin
        q_we = 1'b1; q_waddr = tail_q[sl_idx]; q_wdata = {1'b0, head_q[sl_idx]};
      end
      S_ROT2: begin
        q_we = 1'b1; q_waddr = prev_q; q_wdata = LINK_NIL;
      end
      S_EX_SCAN: begin
        if (!ex_end && ex_hit && !top_q[mi_idx][TW]) begin
          w_re = 1'b1; w_raddr = top_q[mi_idx][TW-1:0];
        end
      end
      S_DR_STEP: begin
        if (!w_rdata[TW]) begin
          w_re = 1'b1; w_raddr = w_rdata[TW-1:0];
        end
      end
      default: begin
        q_re = 1'b0;
      end
    endcase
  end

  mlfq_link_ram #(.DEPTH(MAX_THREADS), .WIDTH(TW + 1)) u_queue_link (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .re_i    (q_re),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  mlfq_link_ram #(.DEPTH(MAX_THREADS), .WIDTH(TW + 1)) u_waiter_link (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .re_i    (w_re),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q <= '0; ts_q <= '0; ms_q <= '0; full_q <= 1'b0; mode_q <= 1'b0;
      for (int i = 0; i < MAX_THREADS; i++) begin
        used_q[i] <= 1'b0; stat_q[i] <= TS_READY; level_q[i] <= '0;
      end
      for (int i = 0; i < LEVELS; i++) begin
        head_q[i] <= '0; tail_q[i] <= '0; filled_q[i] <= 1'b0;
      end
      for (int i = 0; i < MAX_MUTEXES; i++) begin
        mu_used_q[i] <= 1'b0; mu_locked_q[i] <= 1'b0;
        owner_q[i] <= '0; top_q[i] <= LINK_NIL;
      end
      run_q <= '0; run_valid_q <= 1'b0;
      wt_q <= '0; cur_q <= '0; prev_q <= '0; wl_q <= '0; ap_q <= '0;
      prev_nil_q <= 1'b1; rm_then_ap_q <= 1'b0; sl_q <= '0; mi_q <= '0;
      res_thread_q <= '0; res_code_q <= RC_OK; res_fin_q <= 1'b0;
      out_valid_q <= 1'b0; out_thread_q <= '0; out_code_q <= RC_OK; out_fin_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mode_q <= cfg_sched_mode_i;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q <= op_i; ts_q <= thread_slot_i; ms_q <= mutex_slot_i;
            full_q <= full_slice_i;
            state_q <= S_DISP;
          end
        end
        S_DISP: begin
          res_thread_q <= '0; res_code_q <= RC_OK; res_fin_q <= 1'b0;
          state_q <= S_RESP;
          wl_q <= rm_lvl;
          prev_nil_q <= 1'b1;
          cur_q <= head_q[rm_lvl];
          case (op_q)
            OP_CREATE: begin
              if (!free_found) begin
                res_code_q <= RC_FULL;
              end else begin
                used_q[free_idx] <= 1'b1; stat_q[free_idx] <= TS_READY;
                level_q[free_idx] <= '0;
                wt_q <= free_idx; ap_q <= '0;
                res_thread_q <= 4'(free_idx);
                state_q <= S_AP1;
              end
            end
            OP_YIELD: begin
              if (!have_run) begin
                res_code_q <= RC_NOTFOUND;
              end else begin
                level_q[run_q] <= yield_lvl;
                wt_q <= run_q; ap_q <= yield_lvl; rm_then_ap_q <= 1'b1;
                state_q <= filled_q[rm_lvl] ? S_RM_CHK : S_AP1;
              end
            end
            OP_SCHED: begin
              sl_q <= '0;
              state_q <= S_PK_LVL;
            end
            OP_EXIT: begin
              if (!have_run) begin
                res_code_q <= RC_NOTFOUND;
              end else begin
                mi_q <= '0;
                state_q <= S_EX_SCAN;
              end
            end
            OP_QUERY: begin
              if (!t_ok) begin
                res_code_q <= RC_NOTFOUND;
              end else begin
                res_fin_q <= (stat_q[ts_idx] == TS_TERM);
              end
            end
            OP_RELEASE: begin
              if (!t_ok) begin
                res_code_q <= RC_NOTFOUND;
              end else if (stat_q[ts_idx] != TS_TERM) begin
                res_code_q <= RC_BLOCKED;
              end else begin
                used_q[ts_idx] <= 1'b0; stat_q[ts_idx] <= TS_READY;
                level_q[ts_idx] <= '0;
                if (run_valid_q && run_q == ts_idx) begin
                  run_valid_q <= 1'b0;
                end
                wt_q <= ts_idx; rm_then_ap_q <= 1'b0;
                state_q <= filled_q[rm_lvl] ? S_RM_CHK : S_RESP;
              end
            end
            OP_MINIT: begin
              if (32'(ms_q) >= MAX_MUTEXES) begin
                res_code_q <= RC_NOTFOUND;
              end else if (drop_go && !top_q[ms_idx][TW]) begin
                cur_q <= top_q[ms_idx][TW-1:0];
                state_q <= S_DR_STEP;
              end else begin
                mu_used_q[ms_idx] <= 1'b1; mu_locked_q[ms_idx] <= 1'b0;
                top_q[ms_idx] <= LINK_NIL;
              end
            end
            OP_LOCK: begin
              if (!m_ok || !have_run) begin
                res_code_q <= RC_NOTFOUND;
              end else if (!mu_locked_q[ms_idx]) begin
                mu_locked_q[ms_idx] <= 1'b1; owner_q[ms_idx] <= run_q;
              end else begin
                top_q[ms_idx] <= {1'b0, run_q};
                stat_q[run_q] <= TS_BLOCKED;
                run_valid_q <= 1'b0;
                res_code_q <= RC_BLOCKED;
                wt_q <= run_q; ap_q <= level_q[run_q]; rm_then_ap_q <= 1'b1;
                state_q <= filled_q[rm_lvl] ? S_RM_CHK : S_AP1;
              end
            end
            OP_UNLOCK: begin
              if (!m_ok) begin
                res_code_q <= RC_NOTFOUND;
              end else if (!top_q[ms_idx][TW]) begin
                state_q <= S_UL_HO;
              end else begin
                mu_locked_q[ms_idx] <= 1'b0;
              end
            end
            OP_DESTROY: begin
              if (!m_ok) begin
                res_code_q <= RC_NOTFOUND;
              end else if (!top_q[ms_idx][TW]) begin
                cur_q <= top_q[ms_idx][TW-1:0];
                state_q <= S_DR_STEP;
              end else begin
                mu_locked_q[ms_idx] <= 1'b0; mu_used_q[ms_idx] <= 1'b0;
              end
            end
            default: begin
              res_code_q <= RC_NOTFOUND;
            end
          endcase
        end
        S_RM_CHK: begin
          if (rm_hit) begin
            if (prev_nil_q) begin
              if (rm_tail) begin
                filled_q[wl_q] <= 1'b0;
              end else begin
                head_q[wl_q] <= q_rdata[TW-1:0];
              end
            end else if (rm_tail) begin
              tail_q[wl_q] <= prev_q;
            end
            state_q <= rm_then_ap_q ? S_AP1 : S_RESP;
          end else if (rm_tail) begin
            state_q <= rm_then_ap_q ? S_AP1 : S_RESP;
          end else begin
            prev_q <= cur_q; prev_nil_q <= 1'b0; cur_q <= q_rdata[TW-1:0];
          end
        end
        S_AP1: begin
          state_q <= S_AP2;
        end
        S_AP2: begin
          if (!filled_q[ap_q]) begin
            head_q[ap_q] <= wt_q; filled_q[ap_q] <= 1'b1;
          end
          tail_q[ap_q] <= wt_q;
          state_q <= S_RESP;
        end
        S_PK_LVL: begin
          if (scan_end) begin
            res_code_q <= RC_NONE;
            state_q <= S_RESP;
          end else if (filled_q[sl_idx]) begin
            cur_q <= head_q[sl_idx]; prev_nil_q <= 1'b1;
            state_q <= S_PK_CHK;
          end else begin
            sl_q <= sl_q + 1'b1;
          end
        end
        S_PK_CHK: begin
          if (runnable_cur) begin
            stat_q[cur_q] <= TS_SCHED;
            run_q <= cur_q; run_valid_q <= 1'b1;
            res_thread_q <= 4'(cur_q);
            state_q <= (!mode_q && !prev_nil_q) ? S_ROT1 : S_RESP;
          end else if (pk_tail) begin
            sl_q <= sl_q + 1'b1;
            state_q <= S_PK_LVL;
          end else begin
            prev_q <= cur_q; prev_nil_q <= 1'b0; cur_q <= q_rdata[TW-1:0];
          end
        end
        S_ROT1: begin
          state_q <= S_ROT2;
        end
        S_ROT2: begin
          head_q[sl_idx] <= cur_q; tail_q[sl_idx] <= prev_q;
          state_q <= S_RESP;
        end
        S_EX_SCAN: begin
          if (ex_end) begin
            stat_q[run_q] <= TS_TERM; run_valid_q <= 1'b0;
            state_q <= S_RESP;
          end else if (ex_hit && !top_q[mi_idx][TW]) begin
            state_q <= S_EX_HO;
          end else begin
            if (ex_hit) begin
              mu_locked_q[mi_idx] <= 1'b0;
            end
            mi_q <= mi_q + 1'b1;
          end
        end
        S_EX_HO: begin
          top_q[mi_idx] <= w_rdata;
          owner_q[mi_idx] <= top_q[mi_idx][TW-1:0];
          stat_q[top_q[mi_idx][TW-1:0]] <= TS_READY;
          mi_q <= mi_q + 1'b1;
          state_q <= S_EX_SCAN;
        end
        S_UL_HO: begin
          top_q[ms_idx] <= w_rdata;
          owner_q[ms_idx] <= top_q[ms_idx][TW-1:0];
          stat_q[top_q[ms_idx][TW-1:0]] <= TS_READY;
          state_q <= S_RESP;
        end
        S_DR_STEP: begin
          stat_q[cur_q] <= TS_READY;
          if (!w_rdata[TW]) begin
            cur_q <= w_rdata[TW-1:0];
          end else begin
            top_q[ms_idx] <= LINK_NIL; mu_locked_q[ms_idx] <= 1'b0;
            mu_used_q[ms_idx] <= (op_q == OP_MINIT);
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_thread_q <= res_thread_q; out_code_q <= res_code_q; out_fin_q <= res_fin_q;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign result_thread_o = out_thread_q;
  assign result_code_o = out_code_q;
  assign finished_o = out_fin_q;

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_DISP))
    else $error("accepted word not dispatched");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_RESP))
    else $error("result word without response state");

  a_ram_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_we && q_re) |-> (q_waddr != q_raddr))
    else $error("queue link read and written at same entry");

endmodule
